/* rtl/core/cfl_pkg.sv */
package cfl_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int CNT_BITS    = $clog2(SAMPLE_BITS);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic        [SAMPLE_BITS-1:0] mag_type;
   typedef logic [1:0]                    mode_type;

   localparam mode_type MODE_MIN        = 2'd0;
   localparam mode_type MODE_MAX        = 2'd1;
   localparam mode_type MODE_FIRST_ZERO = 2'd2;
   localparam mode_type MODE_LAST_ZERO  = 2'd3;
   localparam mode_type MODE_RESET      = MODE_MAX;

   typedef enum logic [1:0] {
      SIGN_ZERO = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   // earlier sample (a) and later sample (b) around a sign change
   typedef struct packed {
      sample_type xa;
      sample_type ya;
      sample_type xb;
      sample_type yb;
   } pair_type;

   typedef struct packed {
      logic sample;
      logic prep;
      logic mul;
      logic add;
      logic div_step;
      logic fix;
      logic put;
   } cmd_type;

   typedef struct packed {
      logic need_interp;
      logic trivial;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/curve_feature_locator.sv */
// Samples within a curve are taken one per cycle; a sample that is not last gives no beat.
// Last sample with no interpolation (extreme modes, zero end sample, no crossing):
// the result goes straight to put. Crossing with equal x or both y zero: prep, then put.
// Other crossings: prep, multiply, add, the one-bit-per-cycle divider, fix, then put.
// After any last sample the input is stalled until the result enters the output register.
// Synchronous active-high reset: mode = maximum, next sample starts a curve, output empty.
module curve_feature_locator
   import cfl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  mode_type   csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  sample_type req_x_sample,
   input  sample_type req_y_sample,
   input  logic       req_last_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output sample_type rsp_position,
   output logic       rsp_found
);

   cmd_type    cmd;
   status_type status;

   cfl_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .status          (status),
      .req_stall       (req_stall),
      .cmd             (cmd)
   );

   cfl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_x_sample     (req_x_sample),
      .req_y_sample     (req_y_sample),
      .req_last_sample  (req_last_sample),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_position     (rsp_position),
      .rsp_found        (rsp_found)
   );

endmodule

/* rtl/core/cfl_ctrl.sv */
module cfl_ctrl
   import cfl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_sample,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PREP = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_ADD  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_FIX  = 7'b0100000,
      ST_PUT  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.sample = 1'b1;
               if (req_last_sample) begin
                  state_in = status.need_interp ? ST_PREP : ST_PUT;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.trivial ? ST_PUT : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(SAMPLE_BITS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/core/cfl_dp.sv */
module cfl_dp
   import cfl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  mode_type   csr_write_data,
   input  sample_type req_x_sample,
   input  sample_type req_y_sample,
   input  logic       req_last_sample,
   input  logic       rsp_stall,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output sample_type rsp_position,
   output logic       rsp_found
);

   localparam int W = SAMPLE_BITS;

   mode_type   mode_ff, mode_in;
   logic       first_ff, first_in;
   sample_type best_x_ff, best_x_in, best_y_ff, best_y_in;
   sample_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   sign_type   start_sign_ff, start_sign_in;
   logic       fc_seen_ff, fc_seen_in;
   pair_type   fc_pair_ff, fc_pair_in;
   logic       rise_valid_ff, rise_valid_in;
   pair_type   rise_pair_ff, rise_pair_in;
   logic       fall_valid_ff, fall_valid_in;
   pair_type   fall_pair_ff, fall_pair_in;

   pair_type   op_ff, op_in;
   mag_type    dx_ff, dx_in, ma_ff, ma_in;
   logic [W:0] den_ff, den_in;
   logic       up_ff, up_in;
   logic [2*W-1:0] prod_ff, prod_in;
   logic [W:0]     rem_ff, rem_in;
   mag_type        quo_ff, quo_in;

   sample_type res_pos_ff, res_pos_in;
   logic       res_found_ff, res_found_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_position_ff, rsp_position_in;
   logic       rsp_found_ff, rsp_found_in;

   logic y_zero, y_neg, y_pos, p_neg, p_pos, better;
   logic sel_found, sel_interp;
   sample_type sel_pos;
   pair_type   sel_pair;

   sample_type xa, ya, xb, yb;
   mag_type    mb;
   logic [2*W-1:0] sum;
   logic [W+1:0]   shifted, diff;
   logic           ge;

   assign y_zero = (req_y_sample == '0);
   assign y_neg  = req_y_sample[W-1];
   assign y_pos  = !y_zero && !y_neg;
   assign p_neg  = prev_y_ff[W-1];
   assign p_pos  = (prev_y_ff != '0) && !p_neg;

   assign xa = op_ff.xa;
   assign ya = op_ff.ya;
   assign xb = op_ff.xb;
   assign yb = op_ff.yb;

   always_comb begin
      mode_in       = csr_write_enable ? csr_write_data : mode_ff;
      first_in      = first_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      start_sign_in = start_sign_ff;
      fc_seen_in    = fc_seen_ff;
      fc_pair_in    = fc_pair_ff;
      rise_valid_in = rise_valid_ff;
      rise_pair_in  = rise_pair_ff;
      fall_valid_in = fall_valid_ff;
      fall_pair_in  = fall_pair_ff;
      better        = 1'b0;

      if (cmd.sample) begin
         if (first_ff) begin
            best_x_in     = req_x_sample;
            best_y_in     = req_y_sample;
            start_sign_in = y_zero ? SIGN_ZERO : (y_neg ? SIGN_NEG : SIGN_POS);
            fc_seen_in    = y_zero;
            if (y_zero) begin
               fc_pair_in = '{req_x_sample, req_y_sample, req_x_sample, req_y_sample};
            end
            rise_valid_in = 1'b0;
            fall_valid_in = 1'b0;
         end else begin
            better = (mode_ff == MODE_MIN) ? (req_y_sample < best_y_ff)
                                           : (best_y_ff < req_y_sample);
            if (better) begin
               best_x_in = req_x_sample;
               best_y_in = req_y_sample;
            end
            if (!fc_seen_ff && ((start_sign_ff == SIGN_POS && !y_pos) ||
                                (start_sign_ff == SIGN_NEG && !y_neg))) begin
               fc_seen_in = 1'b1;
               fc_pair_in = '{prev_x_ff, prev_y_ff, req_x_sample, req_y_sample};
            end
            if (!p_pos && y_pos) begin
               rise_valid_in = 1'b1;
               rise_pair_in  = '{prev_x_ff, prev_y_ff, req_x_sample, req_y_sample};
            end
            if (!p_neg && y_neg) begin
               fall_valid_in = 1'b1;
               fall_pair_in  = '{prev_x_ff, prev_y_ff, req_x_sample, req_y_sample};
            end
         end
         prev_x_in = req_x_sample;
         prev_y_in = req_y_sample;
         first_in  = req_last_sample;
      end
   end

   // result selection at the end of a curve, from the updated trackers
   always_comb begin
      sel_found  = 1'b0;
      sel_interp = 1'b0;
      sel_pos    = '0;
      sel_pair   = fc_pair_in;
      unique case (mode_ff)
         MODE_MIN, MODE_MAX: begin
            sel_found = 1'b1;
            sel_pos   = best_x_in;
         end
         MODE_FIRST_ZERO: begin
            sel_found  = fc_seen_in;
            sel_interp = fc_seen_in;
         end
         MODE_LAST_ZERO: begin
            sel_pair = y_pos ? rise_pair_in : fall_pair_in;
            priority if (y_zero) begin
               sel_found = 1'b1;
               sel_pos   = req_x_sample;
            end else if (y_pos && rise_valid_in) begin
               sel_found  = 1'b1;
               sel_interp = 1'b1;
            end else if (y_neg && fall_valid_in) begin
               sel_found  = 1'b1;
               sel_interp = 1'b1;
            end
         end
         default: begin
            sel_found = 1'b0;
         end
      endcase
   end

   assign mb = yb[W-1] ? mag_type'(~yb + 1'b1) : mag_type'(yb);

   always_comb begin
      op_in        = op_ff;
      dx_in        = dx_ff;
      ma_in        = ma_ff;
      den_in       = den_ff;
      up_in        = up_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_pos_in   = res_pos_ff;
      res_found_in = res_found_ff;
      sum          = prod_ff + {{W{1'b0}}, den_ff[W:1]};
      shifted      = {rem_ff, quo_ff[W-1]};
      diff         = shifted - {1'b0, den_ff};
      ge           = (shifted >= {1'b0, den_ff});

      if (cmd.sample && req_last_sample) begin
         op_in        = sel_pair;
         res_found_in = sel_found;
         res_pos_in   = sel_pos;
      end
      if (cmd.prep) begin
         ma_in  = ya[W-1] ? mag_type'(~ya + 1'b1) : mag_type'(ya);
         den_in = {1'b0, ma_in} + {1'b0, mb};
         up_in  = (xa < xb);
         dx_in  = up_in ? mag_type'(xb - xa) : mag_type'(xa - xb);
         if (status.trivial) begin
            res_pos_in   = xb;
            res_found_in = 1'b1;
         end
      end
      if (cmd.mul) begin
         prod_in = {{W{1'b0}}, dx_ff} * {{W{1'b0}}, ma_ff};
      end
      if (cmd.add) begin
         // high half is below the divisor, so the quotient fits W bits
         rem_in = {1'b0, sum[2*W-1:W]};
         quo_in = sum[W-1:0];
      end
      if (cmd.div_step) begin
         rem_in = ge ? diff[W:0] : shifted[W:0];
         quo_in = {quo_ff[W-2:0], ge};
      end
      if (cmd.fix) begin
         res_pos_in   = up_ff ? sample_type'(xa + quo_ff) : sample_type'(xa - quo_ff);
         res_found_in = 1'b1;
      end
   end

   always_comb begin
      status.need_interp = sel_interp;
      status.trivial     = (xa == xb) || ((ya == '0) && (yb == '0));
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_position_in = rsp_position_ff;
      rsp_found_in    = rsp_found_ff;
      if (cmd.put) begin
         rsp_valid_in    = 1'b1;
         rsp_position_in = res_found_ff ? res_pos_ff : '0;
         rsp_found_in    = res_found_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         first_ff      <= 1'b1;
         start_sign_ff <= SIGN_ZERO;
         fc_seen_ff    <= 1'b0;
         rise_valid_ff <= 1'b0;
         fall_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         first_ff      <= first_in;
         start_sign_ff <= start_sign_in;
         fc_seen_ff    <= fc_seen_in;
         rise_valid_ff <= rise_valid_in;
         fall_valid_ff <= fall_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      best_x_ff       <= best_x_in;
      best_y_ff       <= best_y_in;
      prev_x_ff       <= prev_x_in;
      prev_y_ff       <= prev_y_in;
      fc_pair_ff      <= fc_pair_in;
      rise_pair_ff    <= rise_pair_in;
      fall_pair_ff    <= fall_pair_in;
      op_ff           <= op_in;
      dx_ff           <= dx_in;
      ma_ff           <= ma_in;
      den_ff          <= den_in;
      up_ff           <= up_in;
      prod_ff         <= prod_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      res_pos_ff      <= res_pos_in;
      res_found_ff    <= res_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_found_ff    <= rsp_found_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_found    = rsp_found_ff;

endmodule
